// ===== src/hai_pkg.sv =====
// Shared constants, types and the hall sector table for the hall angle interpolator.
// Used by every module under src; depends on nothing else.
package hai_pkg;

    // Block parameters.
    localparam int CAL_SAMPLES = 10;
    localparam int ADC_BITS    = 12;

    // Field widths.
    localparam int SAMPLE_W   = 12;
    localparam int PERIOD_W   = 16;
    localparam int HALL_W     = 3;
    localparam int CUR_W      = 21;
    localparam int ANGLE_W    = 16;
    localparam int SPEED_W    = 16;
    localparam int GAIN_W     = 8;
    localparam int OFFSET_W   = 16;
    localparam int ACC_W      = 32;
    localparam int CNT_W      = $clog2(CAL_SAMPLES + 1);
    localparam int DIFF_W     = OFFSET_W + 1;
    localparam int PROD_W     = DIFF_W + GAIN_W + 1;

    // Configuration port.
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 16;
    localparam logic [CFG_INDEX_W-1:0] CFG_PHASE_OFFSET = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CURRENT_GAIN = 1'd1;
    localparam logic [ANGLE_W-1:0]     PHASE_OFFSET_RST = 16'd40050;
    localparam logic [GAIN_W-1:0]      CURRENT_GAIN_RST = 8'd45;

    // Opcodes and hall codes that carry no sector.
    localparam logic OP_ADC_TICK   = 1'b0;
    localparam logic OP_HALL_EVENT = 1'b1;
    localparam logic [HALL_W-1:0] HALL_NONE = 3'd0;
    localparam logic [HALL_W-1:0] HALL_ALL  = 3'd7;

    localparam logic [SAMPLE_W-1:0] ADC_MASK = SAMPLE_W'((1 << ADC_BITS) - 1);

    // Offset averaging: x / CAL_SAMPLES == (x * CAL_RECIP) >> CAL_SHIFT for 16-bit x.
    localparam int CAL_SHIFT   = 24;
    localparam int CAL_RECIP_W = CAL_SHIFT + 1;
    localparam logic [CAL_RECIP_W-1:0] CAL_RECIP =
        CAL_RECIP_W'(((1 << CAL_SHIFT) + CAL_SAMPLES - 1) / CAL_SAMPLES);

    // Step and speed division.
    localparam int DIV_BITS  = 40;
    localparam int DIV_CNT_W = $clog2(DIV_BITS);
    localparam logic [DIV_BITS-1:0] STEP_NUM  = 40'd715827882667;
    localparam logic [DIV_BITS-1:0] SPEED_NUM = 40'd50000000;

    // Stream word layout.
    localparam int S_SAMPLE_A_LSB = 0;
    localparam int S_SAMPLE_B_LSB = S_SAMPLE_A_LSB + SAMPLE_W;
    localparam int S_SAMPLE_C_LSB = S_SAMPLE_B_LSB + SAMPLE_W;
    localparam int S_PERIOD_LSB   = S_SAMPLE_C_LSB + SAMPLE_W;
    localparam int S_HALL_LSB     = S_PERIOD_LSB + PERIOD_W;
    localparam int S_FIELDS_W     = S_HALL_LSB + HALL_W;
    localparam int S_TDATA_W      = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W     = 3 * CUR_W + ANGLE_W + SPEED_W;
    localparam int M_TDATA_W      = ((M_FIELDS_W + 7) / 8) * 8;

    typedef struct packed {
        logic load;
        logic cal_acc;
        logic cal_avg;
        logic tick_run;
        logic div_start;
        logic div_commit;
        logic hall_snap;
        logic emit;
    } hai_cmd_t;

    typedef struct packed {
        logic opcode;
        logic cal_done;
        logic cal_last;
        logic period_zero;
        logic div_done;
        logic out_full;
    } hai_status_t;

    // Sector start angles as 16-bit turn fractions, rounded to nearest.
    function automatic logic [ANGLE_W-1:0] sector_angle(input logic [HALL_W-1:0] hall);
        logic [ANGLE_W-1:0] a;
        unique case (hall)
            3'd1:    a = 16'd54613;
            3'd2:    a = 16'd32768;
            3'd3:    a = 16'd43691;
            3'd4:    a = 16'd10923;
            3'd6:    a = 16'd21845;
            default: a = 16'd0;
        endcase
        return a;
    endfunction

endpackage

// ===== src/hai_div.sv =====
// Radix-2 restoring divider that forms the angle step and the speed from one period.
// Both quotients run side by side, one bit per cycle; uses hai_pkg.
module hai_div
    import hai_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [PERIOD_W-1:0] divisor,
    output logic                done,
    output logic [ACC_W-1:0]    step_q,
    output logic [SPEED_W-1:0]  speed_q
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [PERIOD_W-1:0]  divisor_reg;
    logic [DIV_BITS-1:0]  step_num_reg;
    logic [DIV_BITS-1:0]  speed_num_reg;
    logic [PERIOD_W-1:0]  step_rem_reg;
    logic [PERIOD_W-1:0]  speed_rem_reg;
    logic [ACC_W-1:0]     step_q_reg;
    logic [SPEED_W-1:0]   speed_q_reg;
    logic                 step_ovf_reg;
    logic                 speed_ovf_reg;

    logic [PERIOD_W:0]    step_trial;
    logic [PERIOD_W:0]    speed_trial;
    logic                 step_fit;
    logic                 speed_fit;
    logic [PERIOD_W-1:0]  step_rem_next;
    logic [PERIOD_W-1:0]  speed_rem_next;

    always_comb begin
        step_trial  = {step_rem_reg, step_num_reg[DIV_BITS-1]};
        speed_trial = {speed_rem_reg, speed_num_reg[DIV_BITS-1]};
        step_fit    = step_trial >= {1'b0, divisor_reg};
        speed_fit   = speed_trial >= {1'b0, divisor_reg};
        step_rem_next  = step_fit ? PERIOD_W'(step_trial - {1'b0, divisor_reg})
                                  : step_trial[PERIOD_W-1:0];
        speed_rem_next = speed_fit ? PERIOD_W'(speed_trial - {1'b0, divisor_reg})
                                   : speed_trial[PERIOD_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(DIV_BITS - 1);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // A quotient bit shifted out of the top marks the result for saturation.
    always_ff @(posedge aclk) begin
        if (start) begin
            divisor_reg   <= divisor;
            step_num_reg  <= STEP_NUM;
            speed_num_reg <= SPEED_NUM;
            step_rem_reg  <= '0;
            speed_rem_reg <= '0;
            step_q_reg    <= '0;
            speed_q_reg   <= '0;
            step_ovf_reg  <= 1'b0;
            speed_ovf_reg <= 1'b0;
        end else if (busy_reg) begin
            step_num_reg  <= {step_num_reg[DIV_BITS-2:0], 1'b0};
            speed_num_reg <= {speed_num_reg[DIV_BITS-2:0], 1'b0};
            step_rem_reg  <= step_rem_next;
            speed_rem_reg <= speed_rem_next;
            step_q_reg    <= {step_q_reg[ACC_W-2:0], step_fit};
            speed_q_reg   <= {speed_q_reg[SPEED_W-2:0], speed_fit};
            step_ovf_reg  <= step_ovf_reg | step_q_reg[ACC_W-1];
            speed_ovf_reg <= speed_ovf_reg | speed_q_reg[SPEED_W-1];
        end
    end

    assign done    = done_reg;
    assign step_q  = step_ovf_reg ? '1 : step_q_reg;
    assign speed_q = speed_ovf_reg ? '1 : speed_q_reg;

endmodule

// ===== src/hai_dp.sv =====
// Datapath: input latch, offset calibration, current scaling, angle accumulator,
// configuration registers and the output word register. Uses hai_pkg and hai_div.
module hai_dp
    import hai_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  hai_cmd_t               cmd,
    output hai_status_t            status,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   opcode,
    input  logic [SAMPLE_W-1:0]    sample_a,
    input  logic [SAMPLE_W-1:0]    sample_b,
    input  logic [SAMPLE_W-1:0]    sample_c,
    input  logic [PERIOD_W-1:0]    capture_period,
    input  logic [HALL_W-1:0]      hall_state,
    input  logic                   out_ready,
    output logic                   out_valid,
    output logic [CUR_W-1:0]       current_a,
    output logic [CUR_W-1:0]       current_b,
    output logic [CUR_W-1:0]       current_c,
    output logic [ANGLE_W-1:0]     angle,
    output logic [SPEED_W-1:0]     speed,
    output logic                   calibrated
);

    logic                opcode_reg;
    logic [SAMPLE_W-1:0] samp_reg [3];
    logic [PERIOD_W-1:0] period_reg;
    logic [HALL_W-1:0]   hall_reg;

    logic [ANGLE_W-1:0]  phase_offset_reg;
    logic [GAIN_W-1:0]   gain_reg;

    logic [CNT_W-1:0]    cal_count_reg;
    logic                cal_done_reg;
    logic [OFFSET_W-1:0] off_reg [3];
    logic [ACC_W-1:0]    acc_reg;
    logic [ACC_W-1:0]    step_reg;
    logic [SPEED_W-1:0]  speed_reg;
    logic [CUR_W-1:0]    cur_reg [3];

    logic                out_valid_reg;
    logic [CUR_W-1:0]    out_cur_reg [3];
    logic [ANGLE_W-1:0]  out_angle_reg;
    logic [SPEED_W-1:0]  out_speed_reg;
    logic                out_cal_reg;

    logic [SAMPLE_W-1:0]             samp_in [3];
    logic signed [DIFF_W-1:0]        diff [3];
    logic signed [GAIN_W:0]          gain_s;
    logic signed [PROD_W-1:0]        prod [3];
    logic [OFFSET_W+CAL_RECIP_W-1:0] avg_prod [3];
    logic [CNT_W:0]                  cal_count_inc;
    logic [ANGLE_W-1:0]              snap_angle;
    logic                            hall_valid;
    logic                            div_done;
    logic [ACC_W-1:0]                div_step;
    logic [SPEED_W-1:0]              div_speed;

    hai_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .divisor (period_reg),
        .done    (div_done),
        .step_q  (div_step),
        .speed_q (div_speed)
    );

    always_comb begin
        samp_in[0] = sample_a & ADC_MASK;
        samp_in[1] = sample_b & ADC_MASK;
        samp_in[2] = sample_c & ADC_MASK;
        gain_s     = $signed({1'b0, gain_reg});
        for (int i = 0; i < 3; i++) begin
            diff[i]     = $signed(DIFF_W'(samp_reg[i])) - $signed(DIFF_W'(off_reg[i]));
            prod[i]     = diff[i] * gain_s;
            avg_prod[i] = off_reg[i] * CAL_RECIP;
        end
        cal_count_inc = {1'b0, cal_count_reg} + 1'b1;
        snap_angle    = sector_angle(hall_reg) + phase_offset_reg;
        hall_valid    = (hall_reg != HALL_NONE) && (hall_reg != HALL_ALL);
    end

    always_comb begin
        status.opcode      = opcode_reg;
        status.cal_done    = cal_done_reg;
        status.cal_last    = cal_count_inc >= (CNT_W + 1)'(CAL_SAMPLES);
        status.period_zero = period_reg == '0;
        status.div_done    = div_done;
        status.out_full    = out_valid_reg && !out_ready;
    end

    // Input latch, current lanes and the output word carry no reset.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            opcode_reg <= opcode;
            period_reg <= capture_period;
            hall_reg   <= hall_state;
            for (int i = 0; i < 3; i++) begin
                samp_reg[i] <= samp_in[i];
                cur_reg[i]  <= '0;
            end
        end else if (cmd.tick_run) begin
            for (int i = 0; i < 3; i++) begin
                cur_reg[i] <= prod[i][CUR_W-1:0];
            end
        end
        if (cmd.emit) begin
            for (int i = 0; i < 3; i++) begin
                out_cur_reg[i] <= cur_reg[i];
            end
            out_angle_reg <= acc_reg[ACC_W-1 -: ANGLE_W];
            out_speed_reg <= speed_reg;
            out_cal_reg   <= cal_done_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_offset_reg <= PHASE_OFFSET_RST;
            gain_reg         <= CURRENT_GAIN_RST;
            cal_count_reg    <= '0;
            cal_done_reg     <= 1'b0;
            acc_reg          <= '0;
            step_reg         <= '0;
            speed_reg        <= '0;
            out_valid_reg    <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                off_reg[i] <= '0;
            end
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    CFG_PHASE_OFFSET: phase_offset_reg <= cfg_data[ANGLE_W-1:0];
                    CFG_CURRENT_GAIN: gain_reg         <= cfg_data[GAIN_W-1:0];
                endcase
            end
            if (cmd.cal_acc) begin
                cal_count_reg <= cal_count_inc[CNT_W-1:0];
                for (int i = 0; i < 3; i++) begin
                    off_reg[i] <= off_reg[i] + OFFSET_W'(samp_reg[i]);
                end
            end
            if (cmd.cal_avg) begin
                cal_done_reg <= 1'b1;
                for (int i = 0; i < 3; i++) begin
                    off_reg[i] <= avg_prod[i][CAL_SHIFT +: OFFSET_W];
                end
            end
            if (cmd.tick_run) begin
                acc_reg <= acc_reg + step_reg;
            end
            if (cmd.div_commit) begin
                step_reg  <= div_step;
                speed_reg <= div_speed;
            end
            if (cmd.hall_snap && hall_valid) begin
                acc_reg <= {snap_angle, {(ACC_W - ANGLE_W){1'b0}}};
            end
            if (cmd.emit) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign current_a  = out_cur_reg[0];
    assign current_b  = out_cur_reg[1];
    assign current_c  = out_cur_reg[2];
    assign angle      = out_angle_reg;
    assign speed      = out_speed_reg;
    assign calibrated = out_cal_reg;

`ifndef SYNTHESIS
    a_cal_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cal_count_reg <= CNT_W'(CAL_SAMPLES))
        else $error("calibration count ran past the sample count");

    a_cal_done_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        !$fell(cal_done_reg))
        else $error("calibrated flag dropped without reset");

    a_cal_done_count: assert property (@(posedge aclk) disable iff (!aresetn)
        cal_done_reg |-> cal_count_reg == CNT_W'(CAL_SAMPLES))
        else $error("calibration finished with a short sample count");

    a_emit_only_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> !(out_valid_reg && !out_ready))
        else $error("output word overwritten while stalled");
`endif

endmodule

// ===== src/hai_ctrl.sv =====
// Controller state machine: sequences one word at a time through the datapath.
// Drives hai_cmd_t and reads hai_status_t from hai_pkg.
module hai_ctrl
    import hai_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  hai_status_t status,
    output hai_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_CAL_AVG,
        ST_DIV_WAIT,
        ST_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                if (status.opcode == OP_ADC_TICK) begin
                    if (!status.cal_done) begin
                        cmd.cal_acc = 1'b1;
                        state_next  = status.cal_last ? ST_CAL_AVG : ST_EMIT;
                    end else begin
                        cmd.tick_run = 1'b1;
                        state_next   = ST_EMIT;
                    end
                end else if (status.period_zero) begin
                    cmd.hall_snap = 1'b1;
                    state_next    = ST_EMIT;
                end else begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV_WAIT;
                end
            end
            ST_CAL_AVG: begin
                cmd.cal_avg = 1'b1;
                state_next  = ST_EMIT;
            end
            ST_DIV_WAIT: begin
                if (status.div_done) begin
                    cmd.div_commit = 1'b1;
                    cmd.hall_snap  = 1'b1;
                    state_next     = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!status.out_full) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign in_ready = state_reg == ST_IDLE;

endmodule

// ===== src/hall_angle_interpolator.sv =====
// Hall angle interpolator: rotor angle from three hall sensors plus calibrated
// phase currents. Top level; uses hai_pkg, hai_ctrl and hai_dp.
//
// Usage:
//   The s_axis channel takes one word per event. tuser selects the kind: an ADC
//   tick carries three phase samples, a hall event carries the capture period and
//   the hall code. Every accepted word yields exactly one m_axis word holding the
//   three scaled currents, the angle, the speed, and the calibrated flag in tuser.
//   The first CAL_SAMPLES ticks average the phase offsets and report zero currents.
//   Words are handled one at a time. An ADC tick passes the dispatch and emit states
//   (and the calibration-average state on the tick that ends calibration), as does a
//   hall event with a zero period; a nonzero period also waits in the divide-wait state
//   on the 40-step bit-serial divider for the step and speed quotients. s_axis_tready
//   rises at the edge that loads the result, so the next word can enter while a
//   result still waits. If m_axis is stalled, the finished word holds and the
//   following result waits in the controller until it frees.
//   The configuration port (cfg_wr_en, cfg_index, cfg_data) writes phase_offset
//   and current_gain; write only while the block is idle. Synchronous active-low
//   reset clears the control, calibration and angle state and restores the register
//   defaults; no word is pending after reset.
module hall_angle_interpolator
    import hai_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // sample_a[11:0], sample_b[23:12], sample_c[35:24], capture_period[51:36],
    // hall_state[54:52], zero fill above
    input  logic [S_TDATA_W-1:0]   s_axis_tdata,
    // opcode
    input  logic                   s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // current_a[20:0], current_b[41:21], current_c[62:42], angle[78:63],
    // speed[94:79], zero fill above
    output logic [M_TDATA_W-1:0]   m_axis_tdata,
    // calibrated
    output logic                   m_axis_tuser,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    hai_cmd_t           cmd;
    hai_status_t        status;
    logic [CUR_W-1:0]   current_a;
    logic [CUR_W-1:0]   current_b;
    logic [CUR_W-1:0]   current_c;
    logic [ANGLE_W-1:0] angle;
    logic [SPEED_W-1:0] speed;

    hai_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    hai_dp u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .status         (status),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .opcode         (s_axis_tuser),
        .sample_a       (s_axis_tdata[S_SAMPLE_A_LSB +: SAMPLE_W]),
        .sample_b       (s_axis_tdata[S_SAMPLE_B_LSB +: SAMPLE_W]),
        .sample_c       (s_axis_tdata[S_SAMPLE_C_LSB +: SAMPLE_W]),
        .capture_period (s_axis_tdata[S_PERIOD_LSB +: PERIOD_W]),
        .hall_state     (s_axis_tdata[S_HALL_LSB +: HALL_W]),
        .out_ready      (m_axis_tready),
        .out_valid      (m_axis_tvalid),
        .current_a      (current_a),
        .current_b      (current_b),
        .current_c      (current_c),
        .angle          (angle),
        .speed          (speed),
        .calibrated     (m_axis_tuser)
    );

    assign m_axis_tdata = M_TDATA_W'({speed, angle, current_c, current_b, current_a});

endmodule

// ===== tb/sv/tb_hall_angle_interpolator.sv =====
// Self-checking testbench for hall_angle_interpolator: a scripted opening plus random
// phases under different register settings, with every result word checked against a
// cycle-free model of the angle, speed and current math. Depends on hai_pkg and the RTL.
`timescale 1ns / 1ps

module tb_hall_angle_interpolator;
    import hai_pkg::*;

    localparam int RESET_CYCLES    = 10;
    localparam int IDLE_PERCENT    = 22;
    localparam int PHASES          = 6;
    localparam int WORDS_PER_PHASE = 155;
    localparam int STEADY_FROM     = 500;
    localparam int STEADY_TO       = 650;
    localparam int HOLD_AT         = 300;
    localparam int HOLD_CYCLES     = 400;
    localparam int DRAIN_CYCLES    = 60;
    // Longest quiet span of a good run is the receiver hold plus one divide.
    localparam int WATCHDOG_CYCLES = 3000;

    typedef struct packed {
        logic                opcode;
        logic [SAMPLE_W-1:0] sample_a;
        logic [SAMPLE_W-1:0] sample_b;
        logic [SAMPLE_W-1:0] sample_c;
        logic [PERIOD_W-1:0] capture_period;
        logic [HALL_W-1:0]   hall_state;
    } sensor_word_t;

    typedef struct packed {
        logic signed [CUR_W-1:0] current_a;
        logic signed [CUR_W-1:0] current_b;
        logic signed [CUR_W-1:0] current_c;
        logic [ANGLE_W-1:0]      angle;
        logic [SPEED_W-1:0]      speed;
        logic                    calibrated;
    } rotor_word_t;

    typedef struct packed {
        sensor_word_t word;
        logic         typed;
        rotor_word_t  want;
    } script_row_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [S_TDATA_W-1:0]   s_axis_tdata = '0;
    logic                   s_axis_tuser = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_axis_tdata;
    logic                   m_axis_tuser;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = CFG_PHASE_OFFSET;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // Model state, mirrored from the register writes and the accepted words.
    logic [OFFSET_W-1:0] phase_offset_m;
    logic [GAIN_W-1:0]   gain_m;
    logic [4:0]          cal_count_m;
    logic                cal_done_m;
    logic [OFFSET_W-1:0] offset_m [3];
    logic [ACC_W-1:0]    angle_acc_m;
    logic [ACC_W-1:0]    step_m;
    logic [SPEED_W-1:0]  speed_m;

    logic [ANGLE_W-1:0] sector_turn [8] = '{16'd0, 16'd54613, 16'd32768, 16'd43691,
                                            16'd10923, 16'd0, 16'd21845, 16'd0};
    string field_names [6] = '{"current_a", "current_b", "current_c",
                               "angle", "speed", "calibrated"};

    rotor_word_t rotor_words_due [$];
    logic        typed_row_q = 1'b0;
    rotor_word_t typed_want_q = '0;
    int          faults = 0;
    int          words_taken = 0;
    int          results_seen = 0;
    int          quiet_cycles = 0;

    hall_angle_interpolator i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #5 aclk = ~aclk;

    task automatic report_fault(input string msg);
        $display("[%0t] result %0d: %s", $time, results_seen, msg);
        faults++;
    endtask

    function automatic rotor_word_t predict_rotor_word(input sensor_word_t w);
        rotor_word_t         r;
        logic [SAMPLE_W-1:0] smp [3];
        int                  amps [3];
        longint unsigned     quot;
        r = '0;
        amps = '{0, 0, 0};
        smp[0] = w.sample_a & ADC_MASK;
        smp[1] = w.sample_b & ADC_MASK;
        smp[2] = w.sample_c & ADC_MASK;
        if (w.opcode == OP_ADC_TICK) begin
            if (!cal_done_m) begin
                cal_count_m = cal_count_m + 5'd1;
                for (int i = 0; i < 3; i++)
                    offset_m[i] = offset_m[i] + OFFSET_W'(smp[i]);
                if (cal_count_m >= CAL_SAMPLES) begin
                    cal_done_m = 1'b1;
                    for (int i = 0; i < 3; i++)
                        offset_m[i] = OFFSET_W'(offset_m[i] / CAL_SAMPLES);
                end
            end else begin
                for (int i = 0; i < 3; i++)
                    amps[i] = (int'(smp[i]) - int'(offset_m[i])) * int'(gain_m);
                angle_acc_m = angle_acc_m + step_m;
            end
        end else begin
            if (w.capture_period != '0) begin
                quot = 64'(STEP_NUM) / 64'(w.capture_period);
                step_m = (quot > 64'hFFFF_FFFF) ? '1 : quot[31:0];
                quot = 64'(SPEED_NUM) / 64'(w.capture_period);
                speed_m = (quot > 64'hFFFF) ? '1 : quot[15:0];
            end
            // Codes with all sensors equal carry no sector and leave the angle alone.
            if (w.hall_state != HALL_NONE && w.hall_state != HALL_ALL)
                angle_acc_m = {ANGLE_W'(sector_turn[w.hall_state] + phase_offset_m),
                               16'h0000};
        end
        r.current_a  = CUR_W'(amps[0]);
        r.current_b  = CUR_W'(amps[1]);
        r.current_c  = CUR_W'(amps[2]);
        r.angle      = angle_acc_m[31:16];
        r.speed      = speed_m;
        r.calibrated = cal_done_m;
        return r;
    endfunction

    always @(posedge aclk) begin : monitor
        sensor_word_t w;
        rotor_word_t  got;
        rotor_word_t  want;
        longint       got_f [6];
        longint       want_f [6];
        if (!aresetn) begin
            phase_offset_m = PHASE_OFFSET_RST;
            gain_m         = CURRENT_GAIN_RST;
            cal_count_m    = '0;
            cal_done_m     = 1'b0;
            offset_m       = '{'0, '0, '0};
            angle_acc_m    = '0;
            step_m         = '0;
            speed_m        = '0;
            quiet_cycles   = 0;
        end else begin
            quiet_cycles++;
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_PHASE_OFFSET: phase_offset_m = cfg_data[OFFSET_W-1:0];
                    CFG_CURRENT_GAIN: gain_m = cfg_data[GAIN_W-1:0];
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) begin
                w.opcode         = s_axis_tuser;
                w.sample_a       = s_axis_tdata[S_SAMPLE_A_LSB +: SAMPLE_W];
                w.sample_b       = s_axis_tdata[S_SAMPLE_B_LSB +: SAMPLE_W];
                w.sample_c       = s_axis_tdata[S_SAMPLE_C_LSB +: SAMPLE_W];
                w.capture_period = s_axis_tdata[S_PERIOD_LSB +: PERIOD_W];
                w.hall_state     = s_axis_tdata[S_HALL_LSB +: HALL_W];
                want = predict_rotor_word(w);
                if (typed_row_q)
                    want = typed_want_q;
                rotor_words_due.push_back(want);
                words_taken++;
                quiet_cycles = 0;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.current_a  = m_axis_tdata[0 +: CUR_W];
                got.current_b  = m_axis_tdata[CUR_W +: CUR_W];
                got.current_c  = m_axis_tdata[2*CUR_W +: CUR_W];
                got.angle      = m_axis_tdata[3*CUR_W +: ANGLE_W];
                got.speed      = m_axis_tdata[3*CUR_W+ANGLE_W +: SPEED_W];
                got.calibrated = m_axis_tuser;
                if (rotor_words_due.size() == 0) begin
                    report_fault("result word with nothing expected");
                end else begin
                    want = rotor_words_due.pop_front();
                    got_f  = '{longint'(got.current_a), longint'(got.current_b),
                               longint'(got.current_c), longint'(got.angle),
                               longint'(got.speed), longint'(got.calibrated)};
                    want_f = '{longint'(want.current_a), longint'(want.current_b),
                               longint'(want.current_c), longint'(want.angle),
                               longint'(want.speed), longint'(want.calibrated)};
                    for (int i = 0; i < 6; i++)
                        if (got_f[i] != want_f[i])
                            report_fault($sformatf("%s is %0d, expected %0d",
                                                   field_names[i], got_f[i], want_f[i]));
                end
                results_seen++;
                quiet_cycles = 0;
            end
        end
    end

    // Receiver: random stalls, one long hold so the block backs up, and a steady stretch.
    initial begin : receiver
        int  hold_left;
        bit  hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end else if (!hold_done && results_seen >= HOLD_AT) begin
                m_axis_tready <= 1'b0;
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end else if (results_seen >= STEADY_FROM && results_seen < STEADY_TO) begin
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= IDLE_PERCENT);
            end
        end
    end

    initial begin : watchdog
        while (quiet_cycles < WATCHDOG_CYCLES)
            @(negedge aclk);
        $display("FAIL hall_angle_interpolator");
        $finish;
    end

    function automatic script_row_t plain_row(input logic op, input int a, input int b,
                                              input int c, input int period, input int hall);
        script_row_t row;
        row = '0;
        row.word = '{op, SAMPLE_W'(a), SAMPLE_W'(b), SAMPLE_W'(c), PERIOD_W'(period),
                     HALL_W'(hall)};
        return row;
    endfunction

    // Rows whose result is plain from the rules: no currents, angle and speed given.
    function automatic script_row_t known_row(input logic op, input int period,
                                              input int hall, input int angle,
                                              input int speed);
        script_row_t row;
        row = plain_row(op, 0, 0, 0, period, hall);
        row.typed = 1'b1;
        row.want.angle = ANGLE_W'(angle);
        row.want.speed = SPEED_W'(speed);
        return row;
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    task automatic send_word(input sensor_word_t w, input logic typed, input rotor_word_t want);
        while (!(words_taken >= STEADY_FROM && words_taken < STEADY_TO) &&
               $urandom_range(99) < IDLE_PERCENT) begin
            s_axis_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= w.opcode;
        s_axis_tdata  <= S_TDATA_W'({w.hall_state, w.capture_period, w.sample_c,
                                     w.sample_b, w.sample_a});
        typed_row_q   <= typed;
        typed_want_q  <= want;
        do @(posedge aclk); while (!s_axis_tready);
        @(negedge aclk);
    endtask

    initial begin : stimulus
        script_row_t         script [$];
        sensor_word_t        w;
        logic [OFFSET_W-1:0] new_offset;
        logic [GAIN_W-1:0]   new_gain;
        // Calibration runs on ten ticks: phase A reads zero, phase B full scale, so
        // later currents reach both extremes. Hall rows walk the saturation edges.
        script.push_back(known_row(OP_ADC_TICK, 0, 0, 0, 0));
        script[0].word.sample_b = '1;
        script.push_back(known_row(OP_HALL_EVENT, 0, HALL_NONE, 0, 0));
        script.push_back(known_row(OP_HALL_EVENT, 0, HALL_ALL, 0, 0));
        script.push_back(known_row(OP_HALL_EVENT, 1, 5, 40050, 65535));
        script.push_back(plain_row(OP_ADC_TICK, 0, 4095, 4095, 0, 0));
        script.push_back(plain_row(OP_HALL_EVENT, 0, 0, 0, 65535, 1));
        script.push_back(plain_row(OP_ADC_TICK, 0, 4095, 2048, 0, 0));
        script.push_back(plain_row(OP_HALL_EVENT, 0, 0, 0, 166, 4));
        script.push_back(plain_row(OP_ADC_TICK, 0, 4095, 1, 0, 0));
        script.push_back(plain_row(OP_HALL_EVENT, 0, 0, 0, 167, 6));
        script.push_back(plain_row(OP_ADC_TICK, 0, 4095, 4094, 0, 0));
        script.push_back(plain_row(OP_HALL_EVENT, 0, 0, 0, 762, 2));
        script.push_back(plain_row(OP_ADC_TICK, 0, 4095, 100, 0, 0));
        script.push_back(plain_row(OP_HALL_EVENT, 0, 0, 0, 763, 3));
        script.push_back(plain_row(OP_ADC_TICK, 0, 4095, 3000, 0, 0));
        script.push_back(plain_row(OP_ADC_TICK, 0, 4095, 7, 0, 0));
        script.push_back(plain_row(OP_ADC_TICK, 0, 4095, 500, 0, 0));
        script.push_back(plain_row(OP_ADC_TICK, 0, 4095, 1234, 0, 0));
        script.push_back(plain_row(OP_ADC_TICK, 4095, 0, 4095, 0, 0));
        script.push_back(plain_row(OP_ADC_TICK, 0, 4095, 0, 0, 0));
        script.push_back(plain_row(OP_HALL_EVENT, 0, 0, 0, 0, HALL_ALL));
        script.push_back(plain_row(OP_ADC_TICK, 2048, 2048, 2048, 0, 0));
        script.push_back(plain_row(OP_HALL_EVENT, 0, 0, 0, 1000, 5));
        script.push_back(plain_row(OP_ADC_TICK, 4095, 4095, 4095, 0, 0));

        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        foreach (script[i])
            send_word(script[i].word, script[i].typed, script[i].want);

        for (int phase = 0; phase < PHASES; phase++) begin
            s_axis_tvalid <= 1'b0;
            while (rotor_words_due.size() != 0 || !s_axis_tready)
                @(negedge aclk);
            case (phase)
                0:       begin new_offset = '0; new_gain = '1; end
                1:       begin new_offset = '1; new_gain = '0; end
                4:       begin new_offset = '1; new_gain = '1; end
                5:       begin new_offset = '0; new_gain = GAIN_W'(1); end
                default: begin
                    new_offset = OFFSET_W'($urandom);
                    new_gain   = GAIN_W'($urandom);
                end
            endcase
            cfg_wr_en <= 1'b1;
            cfg_index <= CFG_PHASE_OFFSET;
            cfg_data  <= CFG_DATA_W'(new_offset);
            @(negedge aclk);
            cfg_index <= CFG_CURRENT_GAIN;
            cfg_data  <= CFG_DATA_W'(new_gain);
            @(negedge aclk);
            cfg_wr_en <= 1'b0;

            repeat (WORDS_PER_PHASE) begin
                w.opcode   = ($urandom_range(99) < 25) ? OP_HALL_EVENT : OP_ADC_TICK;
                w.sample_a = pick_sample();
                w.sample_b = pick_sample();
                w.sample_c = pick_sample();
                case ($urandom_range(9))
                    0:       w.capture_period = '0;
                    1:       w.capture_period = PERIOD_W'($urandom_range(1, 200));
                    2:       w.capture_period = PERIOD_W'($urandom_range(160, 170));
                    3:       w.capture_period = PERIOD_W'($urandom_range(755, 770));
                    4:       w.capture_period = '1;
                    default: w.capture_period = PERIOD_W'($urandom);
                endcase
                if ($urandom_range(9) < 8)
                    w.hall_state = HALL_W'($urandom_range(1, 6));
                else
                    w.hall_state = $urandom_range(1) ? HALL_ALL : HALL_NONE;
                send_word(w, 1'b0, '0);
            end
        end

        s_axis_tvalid <= 1'b0;
        while (rotor_words_due.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (rotor_words_due.size() != 0)
            report_fault("expected result words never arrived");
        if (faults == 0)
            $display("PASS hall_angle_interpolator");
        else
            $display("FAIL hall_angle_interpolator");
        $finish;
    end

endmodule

// ===== hall_angle_interpolator.f =====
src/hai_pkg.sv
src/hai_div.sv
src/hai_dp.sv
src/hai_ctrl.sv
src/hall_angle_interpolator.sv
tb/sv/tb_hall_angle_interpolator.sv
